@@ rtl/pdlz_pkg.sv @@
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared types and constants for the PalmDoc LZ77 decompressor: command
// codes passed from the front end to the back end, and decode constants.
// ----------------------------------------------------------------------------
package pdlz_pkg;

    localparam int HIST_DEPTH_DEFAULT = 2048;
    localparam int LEN_BITS           = 3;
    localparam int LEN_BIAS           = 3;
    localparam int DIST_W             = 11;
    localparam int CODE_DIST_MSB      = 13;
    localparam int RUN_W              = 4;
    localparam int CMD_FIFO_DEPTH     = 2;

    localparam logic [7:0] LIT_COUNT_MAX = 8'd8;
    localparam logic [7:0] PAIR_LO       = 8'h80;
    localparam logic [7:0] SPACE_LO      = 8'hc0;
    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] SPACE_XOR     = 8'h80;

    typedef enum logic [1:0] {
        CMD_LIT   = 2'd0,
        CMD_SPACE = 2'd1,
        CMD_COPY  = 2'd2,
        CMD_ERR   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              start;
        logic [7:0]        data;
        logic [DIST_W-1:0] distance;
        logic [RUN_W-1:0]  len;
    } cmd_t;

endpackage

@@ rtl/pdlz_front.sv @@
// ----------------------------------------------------------------------------
// pdlz_front
// Accepts compressed bytes, tracks literal runs and pending pairs, checks
// back reference distances and issues one command per decoded token.
// ----------------------------------------------------------------------------
module pdlz_front import pdlz_pkg::*; #(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_start_of_record,
    input  logic       cmd_full,
    output logic       cmd_push,
    output cmd_t       cmd_data
);

    localparam int PW = $clog2(HISTORY_DEPTH + 1);

    logic [RUN_W-1:0] lit_rem_reg, lit_rem_next;
    logic             pend_reg, pend_next;
    logic [7:0]       high_reg, high_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic             start_pend_reg, start_pend_next;

    logic             accept;
    logic [RUN_W-1:0] lit_eff;
    logic             pend_eff;
    logic [7:0]       high_eff;
    logic [PW-1:0]    prod_eff;
    logic [15:0]      code;
    logic [DIST_W-1:0] distance;
    logic [RUN_W-1:0] len;
    logic [RUN_W-1:0] add_cnt;
    logic [PW:0]      prod_sum;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        lit_eff  = s_start_of_record ? '0 : lit_rem_reg;
        pend_eff = s_start_of_record ? 1'b0 : pend_reg;
        high_eff = s_start_of_record ? 8'd0 : high_reg;
        prod_eff = s_start_of_record ? '0 : prod_reg;
        code     = {high_eff, s_in_byte};
        distance = code[CODE_DIST_MSB:LEN_BITS];
        len      = RUN_W'(code[LEN_BITS-1:0]) + RUN_W'(LEN_BIAS);

        lit_rem_next      = lit_rem_reg;
        pend_next         = pend_reg;
        high_next         = high_reg;
        prod_next         = prod_reg;
        start_pend_next   = start_pend_reg;
        cmd_push          = 1'b0;
        add_cnt           = '0;
        cmd_data.kind     = CMD_LIT;
        cmd_data.start    = s_start_of_record || start_pend_reg;
        cmd_data.data     = s_in_byte;
        cmd_data.distance = distance;
        cmd_data.len      = len;

        if (accept) begin
            lit_rem_next = lit_eff;
            pend_next    = pend_eff;
            high_next    = high_eff;
            if (pend_eff) begin
                pend_next = 1'b0;
                high_next = 8'd0;
                cmd_push  = 1'b1;
                if (distance == '0 || PW'(distance) > prod_eff) begin
                    cmd_data.kind = CMD_ERR;
                end else begin
                    cmd_data.kind = CMD_COPY;
                    add_cnt       = len;
                end
            end else if (lit_eff != '0) begin
                lit_rem_next  = lit_eff - 1'b1;
                cmd_push      = 1'b1;
                cmd_data.kind = CMD_LIT;
                add_cnt       = RUN_W'(1);
            end else if (s_in_byte != 8'd0 && s_in_byte <= LIT_COUNT_MAX) begin
                lit_rem_next = RUN_W'(s_in_byte);
            end else if (s_in_byte < PAIR_LO) begin
                cmd_push      = 1'b1;
                cmd_data.kind = CMD_LIT;
                add_cnt       = RUN_W'(1);
            end else if (s_in_byte >= SPACE_LO) begin
                cmd_push      = 1'b1;
                cmd_data.kind = CMD_SPACE;
                add_cnt       = RUN_W'(2);
            end else begin
                pend_next = 1'b1;
                high_next = s_in_byte;
            end

            prod_sum  = {1'b0, prod_eff} + (PW + 1)'(add_cnt);
            prod_next = (prod_sum > (PW + 1)'(HISTORY_DEPTH)) ?
                        PW'(HISTORY_DEPTH) : prod_sum[PW-1:0];
            start_pend_next = cmd_push ? 1'b0 : (s_start_of_record || start_pend_reg);
        end else begin
            prod_sum = {1'b0, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_rem_reg    <= '0;
            pend_reg       <= 1'b0;
            high_reg       <= 8'd0;
            prod_reg       <= '0;
            start_pend_reg <= 1'b0;
        end else begin
            lit_rem_reg    <= lit_rem_next;
            pend_reg       <= pend_next;
            high_reg       <= high_next;
            prod_reg       <= prod_next;
            start_pend_reg <= start_pend_next;
        end
    end

endmodule

@@ rtl/pdlz_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// pdlz_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pdlz_cmd_fifo import pdlz_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int IW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t          entry_reg [CMD_FIFO_DEPTH];
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(CMD_FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/pdlz_back.sv @@
// ----------------------------------------------------------------------------
// pdlz_back
// Executes decode commands: writes produced bytes into the history memory,
// replays back references from it, and drives the registered result port.
// ----------------------------------------------------------------------------
module pdlz_back import pdlz_pkg::*; #(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_empty,
    input  cmd_t       cmd_data,
    output logic       cmd_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_error
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_PUT  = 4'b0100,
        S_ERR  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    cmd_kind_t         kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        byte2_reg, byte2_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [RUN_W-1:0]  rem_reg, rem_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_error_reg, out_error_next;

    logic [7:0]        hist_mem [HISTORY_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we, rd_en;
    logic [7:0]        wdata;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     dist_ext;
    logic [AW:0]       wrap_addr;
    logic              out_free;

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;
    assign m_error    = out_error_reg;
    assign out_free   = !out_valid_reg || m_ready;

    assign dist_ext  = AW'(dist_reg);
    assign wrap_addr = {1'b0, wp_reg} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, dist_ext};
    assign rd_addr   = (wp_reg >= dist_ext) ? (wp_reg - dist_ext) : wrap_addr[AW-1:0];
    assign wdata     = (kind_reg == CMD_COPY) ? rdata_reg : byte_reg;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        byte2_next     = byte2_reg;
        dist_next      = dist_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_error_next = out_error_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop    = 1'b1;
                    kind_next  = cmd_data.kind;
                    byte2_next = cmd_data.data ^ SPACE_XOR;
                    dist_next  = cmd_data.distance;
                    if (cmd_data.start) begin
                        wp_next = '0;
                    end
                    case (cmd_data.kind)
                        CMD_SPACE: begin
                            byte_next  = SPACE_CHAR;
                            rem_next   = RUN_W'(2);
                            state_next = S_PUT;
                        end
                        CMD_COPY: begin
                            byte_next  = cmd_data.data;
                            rem_next   = cmd_data.len;
                            state_next = S_READ;
                        end
                        CMD_ERR: begin
                            byte_next  = cmd_data.data;
                            rem_next   = RUN_W'(1);
                            state_next = S_ERR;
                        end
                        default: begin
                            byte_next  = cmd_data.data;
                            rem_next   = RUN_W'(1);
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_READ: begin
                rd_en      = 1'b1;
                state_next = S_PUT;
            end
            S_PUT: begin
                if (out_free) begin
                    mem_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = wdata;
                    out_last_next  = (rem_reg == RUN_W'(1));
                    out_error_next = 1'b0;
                    wp_next        = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == RUN_W'(1)) begin
                        state_next = S_IDLE;
                    end else if (kind_reg == CMD_COPY) begin
                        state_next = S_READ;
                    end else begin
                        byte_next = byte2_reg;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    out_last_next  = 1'b1;
                    out_error_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_reg] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        byte_reg      <= byte_next;
        byte2_reg     <= byte2_next;
        dist_reg      <= dist_next;
        rem_reg       <= rem_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_error_reg <= out_error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/palmdoc_lz77_decompressor_core.sv @@
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_core
// PalmDoc LZ77 decompressor: one compressed byte in per transfer on the s_
// channel, decoded bytes out one per transfer on the m_ channel.
//
// s_start_of_record marks the first byte of a record and clears the decode
// state; history is only read inside the current record. Each result
// carries m_last on the final byte caused by an input byte, and m_error
// with a zero byte when a back reference is out of range.
// A front end accepts a byte per cycle while its two-entry command queue
// has room; count bytes and pair lead bytes are absorbed there without
// issuing a command. The back end runs one command at a time against the
// history RAM: a space pair writes a space and then its second byte, and a
// copy reads each byte through a registered RAM read before writing it.
// A stalled m_ready holds the result register; the back end and then the
// queue fill and s_ready drops. Reset clears all control state; the
// history RAM is not cleared.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_core import pdlz_pkg::*; #(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_start_of_record,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_error
);

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_in, cmd_out;

    pdlz_front #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_start_of_record (s_start_of_record),
        .cmd_full          (cmd_full),
        .cmd_push          (cmd_push),
        .cmd_data          (cmd_in)
    );

    pdlz_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    pdlz_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_empty  (cmd_empty),
        .cmd_data   (cmd_out),
        .cmd_pop    (cmd_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_error    (m_error)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for palmdoc_lz77_decompressor_core. A queue of
// compressed bytes (a directed set, then random records made of literals,
// space pairs, literal runs, back references and some noise) feeds a bursty
// driver; every accepted byte runs through a decode model that queues the
// decoded bytes it yields, and a monitor behind a stalling receiver compares
// each output transfer field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module tb import pdlz_pkg::*; ();

    typedef struct packed {
        logic [7:0] data;
        logic       sor;
        logic       hold;
    } comp_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } dec_out_t;

    localparam int HIST = HIST_DEPTH_DEFAULT;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_start_of_record = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_error;

    comp_item_t comp_q[$];
    dec_out_t   decoded_q[$];
    dec_out_t   step_q[$];
    int         fail_cnt = 0;

    // decode model state
    logic [7:0]  hist_mem [0:HIST-1];
    logic [10:0] wr_ptr = '0;
    logic [11:0] produced = '0;
    logic [3:0]  lit_left = '0;
    logic        pair_wait = 1'b0;
    logic [7:0]  pair_hi = '0;

    // stimulus build state
    logic gen_new_rec = 1'b0;
    logic gen_hold = 1'b0;
    int   gen_produced = 0;

    // sender and receiver pacing
    int          burst_left = 8;
    int          gap_left = 0;
    logic [31:0] stall_pat = '1;
    int          pat_left = 31;

    palmdoc_lz77_decompressor_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_start_of_record (s_start_of_record),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_last            (m_last),
        .m_error           (m_error)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic emit_byte(input logic [7:0] v);
        hist_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 11'd1;
        if (produced < 12'(HIST))
            produced = produced + 12'd1;
        step_q.push_back('{v, 1'b0, 1'b0});
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sor);
        logic [15:0] code;
        logic [10:0] distance;
        logic [3:0]  run;
        step_q.delete();
        if (sor) begin
            wr_ptr = '0;
            produced = '0;
            lit_left = '0;
            pair_wait = 1'b0;
            pair_hi = '0;
        end
        if (pair_wait) begin
            code = {pair_hi, b};
            distance = code[CODE_DIST_MSB:LEN_BITS];
            run = 4'(code[LEN_BITS-1:0]) + 4'(LEN_BIAS);
            pair_wait = 1'b0;
            pair_hi = '0;
            if (distance == 0 || 12'(distance) > produced) begin
                step_q.push_back('{8'h00, 1'b0, 1'b1});
            end else begin
                for (int k = 0; k < run; k++)
                    emit_byte(hist_mem[wr_ptr - distance]);
            end
        end else if (lit_left != 0) begin
            lit_left = lit_left - 4'd1;
            emit_byte(b);
        end else if (b >= 8'd1 && b <= LIT_COUNT_MAX) begin
            lit_left = b[3:0];
        end else if (b < PAIR_LO) begin
            emit_byte(b);
        end else if (b >= SPACE_LO) begin
            emit_byte(SPACE_CHAR);
            emit_byte(b ^ SPACE_XOR);
        end else begin
            pair_wait = 1'b1;
            pair_hi = b;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            decoded_q.push_back(step_q[i]);
    endtask

    task automatic add_item(input logic [7:0] b);
        comp_q.push_back('{b, gen_new_rec, gen_hold});
        gen_new_rec = 1'b0;
        gen_hold = 1'b0;
    endtask

    task automatic add_pair(input int d, input int l);
        logic [10:0] dv;
        dv = 11'(d);
        add_item({2'b10, dv[10:5]});
        add_item({dv[4:0], 3'(l - 3)});
    endtask

    task automatic add_produced(input int n);
        gen_produced = gen_produced + n;
        if (gen_produced > HIST)
            gen_produced = HIST;
    endtask

    task automatic build_random(input int target);
        int sel;
        int n;
        int cut;
        int d;
        int lim;
        gen_new_rec = 1'b1;
        gen_hold = 1'b1;
        gen_produced = 0;
        while (comp_q.size() < target) begin
            if (comp_q.size() % 40 == 0)
                gen_hold = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                gen_new_rec = 1'b1;
                gen_produced = 0;
            end else if (sel < 9) begin
                // noise record, tracking resumes at the next record
                repeat ($urandom_range(2, 8))
                    comp_q.push_back('{8'($urandom), 1'($urandom_range(0, 4) == 0), 1'b0});
                gen_new_rec = 1'b1;
                gen_produced = 0;
            end else if (sel < 30 || (sel < 85 && sel >= 55 && gen_produced == 0)) begin
                add_item($urandom_range(0, 15) == 0 ? 8'h00 : 8'($urandom_range(9, 127)));
                add_produced(1);
            end else if (sel < 42) begin
                add_item(8'($urandom_range(192, 255)));
                add_produced(2);
            end else if (sel < 55) begin
                n = $urandom_range(1, 8);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
                add_item(8'(n));
                for (int k = 0; k < cut; k++)
                    add_item(8'($urandom));
                if (cut < n) begin
                    // run cut off by a new record
                    gen_new_rec = 1'b1;
                    gen_produced = 0;
                end else begin
                    add_produced(n);
                end
            end else if (sel < 85) begin
                lim = (gen_produced > 2047) ? 2047 : gen_produced;
                if ($urandom_range(0, 1) == 0 && lim > 16)
                    lim = 16;
                n = $urandom_range(3, 10);
                add_pair($urandom_range(1, lim), n);
                add_produced(n);
            end else if (sel < 90) begin
                // pair lead byte dropped by a new record
                add_item(8'($urandom_range(128, 191)));
                gen_new_rec = 1'b1;
                gen_produced = 0;
            end else begin
                if (gen_produced >= 2047 || $urandom_range(0, 2) == 0)
                    d = 0;
                else
                    d = $urandom_range(gen_produced + 1, 2047);
                add_pair(d, $urandom_range(3, 10));
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        comp_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_in_byte, s_start_of_record);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (comp_q.size() > 0 &&
                             (!comp_q[0].hold || decoded_q.size() == 0)) begin
                    nxt = comp_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_byte <= nxt.data;
                    s_start_of_record <= nxt.sor;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= stall_pat[0];
            if (pat_left == 0) begin
                pat_left <= 31;
                case ($urandom_range(0, 3))
                    0: stall_pat <= '1;
                    1: stall_pat <= $urandom;
                    2: stall_pat <= $urandom & $urandom;
                    default: stall_pat <= $urandom | $urandom;
                endcase
            end else begin
                pat_left <= pat_left - 1;
                stall_pat <= {stall_pat[0], stall_pat[31:1]};
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        dec_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected transfer: out_byte %h last %b error %b",
                       m_out_byte, m_last, m_error);
                fail_cnt++;
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data) begin
                    $error("out_byte expected %h actual %h", want.data, m_out_byte);
                    fail_cnt++;
                end
                if (m_last !== want.last) begin
                    $error("last expected %b actual %b", want.last, m_last);
                    fail_cnt++;
                end
                if (m_error !== want.err) begin
                    $error("error expected %b actual %b", want.err, m_error);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        // directed: extremes, every byte class, bad references, cut-off records
        gen_new_rec = 1'b1;
        add_item(8'h00);
        add_item(8'h7f);
        add_item(8'h09);
        add_item(8'h01);
        add_item(8'hff);
        add_item(8'hc0);
        add_item(8'hff);
        add_pair(1, 10);        // overlapping copy of the last byte
        add_pair(2047, 10);     // distance past the record start
        add_pair(0, 3);         // zero distance
        add_pair(18, 3);        // distance equal to bytes produced
        add_item(8'h85);
        gen_new_rec = 1'b1;
        add_item(8'h41);
        add_item(8'h03);
        gen_new_rec = 1'b1;
        add_item(8'hc1);
        add_item(8'h04);
        add_item(8'h80);
        add_item(8'hc0);
        add_item(8'h01);
        add_item(8'haa);

        build_random(130);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (comp_q.size() != 0 || s_valid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
